// ===== rtl/ivi_pkg.sv =====
`timescale 1ns / 1ps

package ivi_pkg;

  // Fixed field widths.
  localparam int IN_W       = 16;  // raw sensor sample
  localparam int AVG_W      = 17;  // averaged value minus bias
  localparam int VEL_W      = 32;  // integrated velocity
  localparam int BIAS_W     = 16;
  localparam int DL_W       = 16;  // lower dead-zone bound, signed
  localparam int DH_W       = 15;  // upper dead-zone bound, unsigned
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 16;

  // Result buffer depth; it also bounds the results in flight.
  localparam int FIFO_DEPTH = 8;

  typedef enum logic [CFG_IW-1:0] {
    REG_ACCEL_BIAS_X = 3'd0,
    REG_ACCEL_BIAS_Y = 3'd1,
    REG_ACCEL_BIAS_Z = 3'd2,
    REG_GYRO_BIAS_X  = 3'd3,
    REG_GYRO_BIAS_Y  = 3'd4,
    REG_GYRO_BIAS_Z  = 3'd5,
    REG_DEAD_LOW     = 3'd6,
    REG_DEAD_HIGH    = 3'd7
  } cfg_reg_e;

  // Per-sample control shared by all averaging lanes.
  typedef struct packed {
    logic acc;   // a sample is taken this cycle
    logic last;  // it completes the averaging block
  } lane_ctl_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic signed [AVG_W-1:0] rate_x;
    logic signed [AVG_W-1:0] rate_y;
    logic signed [AVG_W-1:0] rate_z;
  } result_t;

endpackage

// ===== rtl/ivi_avg_lane.sv =====
`timescale 1ns / 1ps

// One axis of one sensor: running sum, truncating average by reciprocal
// multiplication, bias subtraction. Three register stages after the sum.
module ivi_avg_lane #(
  parameter int AVG_COUNT = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ivi_pkg::lane_ctl_t                     ctl,
  input  logic signed [ivi_pkg::IN_W-1:0]        sample,
  input  logic signed [ivi_pkg::BIAS_W-1:0]      bias,
  output logic signed [ivi_pkg::AVG_W-1:0]       avg
);

  localparam int L       = $clog2(AVG_COUNT);
  localparam int SUM_W   = ivi_pkg::IN_W + L;
  localparam int SHIFT   = SUM_W + L;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-1:0]        sum_new;
  logic        [SUM_W-1:0]        fin_mag;
  logic                           fin_neg;
  logic        [PROD_W-1:0]       prod;
  logic                           prod_neg;
  logic        [ivi_pkg::IN_W-1:0] quot;
  logic signed [ivi_pkg::AVG_W:0] quot_s;
  logic signed [ivi_pkg::AVG_W:0] diff;

  assign sum_new = sum + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.acc) begin
      sum <= ctl.last ? '0 : sum_new;
    end
  end

  // The quotient is exact for every magnitude below 2^SUM_W.
  always_ff @(posedge clk) begin
    if (ctl.acc && ctl.last) begin
      fin_neg <= sum_new[SUM_W-1];
      fin_mag <= sum_new[SUM_W-1] ? $unsigned(-sum_new) : $unsigned(sum_new);
    end
    prod     <= PROD_W'(fin_mag) * PROD_W'(RECIP);
    prod_neg <= fin_neg;
    avg      <= diff[ivi_pkg::AVG_W-1:0];
  end

  assign quot   = prod[SHIFT +: ivi_pkg::IN_W];
  assign quot_s = prod_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign diff   = quot_s - (ivi_pkg::AVG_W + 1)'(bias);

endmodule

// ===== rtl/ivi_int_lane.sv =====
`timescale 1ns / 1ps

// One velocity axis: dead zone, trapezoid step with saturation, and the
// still counter that clears the stored velocity.
module ivi_int_lane #(
  parameter int STILL_LIMIT = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                commit,
  input  logic signed [ivi_pkg::AVG_W-1:0]    avg,
  input  logic signed [ivi_pkg::DL_W-1:0]     dead_low,
  input  logic        [ivi_pkg::DH_W-1:0]     dead_high,
  output logic signed [ivi_pkg::VEL_W-1:0]    vel
);

  localparam int SC_W = $clog2(STILL_LIMIT + 1);
  localparam int CW   = ivi_pkg::AVG_W + 1;
  localparam int SW   = ivi_pkg::VEL_W + 2;

  logic signed [ivi_pkg::AVG_W-1:0] acc_dz;
  logic signed [ivi_pkg::AVG_W-1:0] last_acc;
  logic signed [ivi_pkg::VEL_W-1:0] last_vel;
  logic        [SC_W-1:0]           still_cnt;
  logic        [SC_W-1:0]           cnt_inc;
  logic                             in_zone;
  logic                             still;
  logic signed [CW-1:0]             diff;
  logic signed [CW-1:0]             half;
  logic signed [SW-1:0]             vsum;

  assign in_zone = (CW'(avg) >= CW'(dead_low)) &&
                   (CW'(avg) <= $signed({3'b000, dead_high}));

  always_ff @(posedge clk) begin
    acc_dz <= in_zone ? '0 : avg;
  end

  // Halving rounds toward zero: add one to a negative difference first.
  assign diff = CW'(acc_dz) - CW'(last_acc);
  assign half = $signed(diff + {{(CW-1){1'b0}}, diff[CW-1]}) >>> 1;
  assign vsum = SW'(last_vel) + SW'(last_acc) + SW'(half);

  always_comb begin
    if (vsum[SW-1:SW-3] == 3'b000 || vsum[SW-1:SW-3] == 3'b111) begin
      vel = vsum[ivi_pkg::VEL_W-1:0];
    end else if (vsum[SW-1]) begin
      vel = {1'b1, {(ivi_pkg::VEL_W-1){1'b0}}};
    end else begin
      vel = {1'b0, {(ivi_pkg::VEL_W-1){1'b1}}};
    end
  end

  assign cnt_inc = still_cnt + SC_W'(acc_dz == '0);
  assign still   = cnt_inc >= SC_W'(STILL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_acc  <= '0;
      last_vel  <= '0;
      still_cnt <= '0;
    end else if (commit) begin
      last_acc  <= acc_dz;
      last_vel  <= still ? '0 : vel;
      still_cnt <= still ? '0 : cnt_inc;
    end
  end

endmodule

// ===== rtl/ivi_out_fifo.sv =====
`timescale 1ns / 1ps

// Buffers result items, each merged from the six lane results, for the consumer.
module ivi_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ivi_pkg::result_t din,
  input  logic             pop,
  output logic             has_item,
  output ivi_pkg::result_t dout
);

  localparam int DEPTH = ivi_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ivi_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign has_item = (count != '0);
  assign dout     = mem[rd_ptr];

endmodule

// ===== rtl/imu_velocity_integrator_unit.sv =====
`timescale 1ns / 1ps
// A result can be taken once the last sample of an averaging block has passed
// the registered sum, multiply, bias, dead-zone and buffer stages.
// Throughput: a sample per cycle while ready; a result per AVG_COUNT samples.
// in_ready drops only when FIFO_DEPTH results are in flight or unread.
// Reset (rst, synchronous) clears sums, counters, integrator state, the
// result buffer and all configuration registers.
module imu_velocity_integrator_unit #(
  parameter int AVG_COUNT   = 16,
  parameter int STILL_LIMIT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Sample channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ivi_pkg::IN_W-1:0]       raw_accel_x,
  input  logic signed [ivi_pkg::IN_W-1:0]       raw_accel_y,
  input  logic signed [ivi_pkg::IN_W-1:0]       raw_accel_z,
  input  logic signed [ivi_pkg::IN_W-1:0]       raw_gyro_x,
  input  logic signed [ivi_pkg::IN_W-1:0]       raw_gyro_y,
  input  logic signed [ivi_pkg::IN_W-1:0]       raw_gyro_z,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ivi_pkg::VEL_W-1:0]      vel_x,
  output logic signed [ivi_pkg::VEL_W-1:0]      vel_y,
  output logic signed [ivi_pkg::VEL_W-1:0]      vel_z,
  output logic signed [ivi_pkg::AVG_W-1:0]      rate_x,
  output logic signed [ivi_pkg::AVG_W-1:0]      rate_y,
  output logic signed [ivi_pkg::AVG_W-1:0]      rate_z,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic        [ivi_pkg::CFG_IW-1:0]     cfg_index,
  input  logic        [ivi_pkg::CFG_DW-1:0]     cfg_data
);

  localparam int SCNT_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam int PEND_W = $clog2(ivi_pkg::FIFO_DEPTH + 1);

  // Configuration registers.
  logic signed [ivi_pkg::BIAS_W-1:0] accel_bias [3];
  logic signed [ivi_pkg::BIAS_W-1:0] gyro_bias  [3];
  logic signed [ivi_pkg::DL_W-1:0]   dead_low;
  logic        [ivi_pkg::DH_W-1:0]   dead_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_bias <= '{default: '0};
      gyro_bias  <= '{default: '0};
      dead_low   <= '0;
      dead_high  <= '0;
    end else if (cfg_we) begin
      case (ivi_pkg::cfg_reg_e'(cfg_index))
        ivi_pkg::REG_ACCEL_BIAS_X: accel_bias[0] <= $signed(cfg_data);
        ivi_pkg::REG_ACCEL_BIAS_Y: accel_bias[1] <= $signed(cfg_data);
        ivi_pkg::REG_ACCEL_BIAS_Z: accel_bias[2] <= $signed(cfg_data);
        ivi_pkg::REG_GYRO_BIAS_X:  gyro_bias[0]  <= $signed(cfg_data);
        ivi_pkg::REG_GYRO_BIAS_Y:  gyro_bias[1]  <= $signed(cfg_data);
        ivi_pkg::REG_GYRO_BIAS_Z:  gyro_bias[2]  <= $signed(cfg_data);
        ivi_pkg::REG_DEAD_LOW:     dead_low      <= $signed(cfg_data);
        ivi_pkg::REG_DEAD_HIGH:    dead_high     <= cfg_data[ivi_pkg::DH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample counting. An item is accepted whenever the number of results
  // that are in the pipeline or waiting in the buffer is below its depth,
  // so the pipeline itself never has to stall.
  logic [SCNT_W-1:0] sample_count;
  logic [PEND_W-1:0] pending;
  logic              accept;
  logic              last;
  logic              out_take;
  ivi_pkg::lane_ctl_t ctl;

  assign in_ready = (pending < PEND_W'(ivi_pkg::FIFO_DEPTH));
  assign accept   = in_valid && in_ready;
  assign last     = (sample_count == SCNT_W'(AVG_COUNT - 1));
  assign out_take = out_valid && out_ready;
  assign ctl.acc  = accept;
  assign ctl.last = last;

  // Valid bits for the four stages behind the sums.
  logic v_fin, v_prod, v_avg, v_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      pending      <= '0;
      v_fin        <= 1'b0;
      v_prod       <= 1'b0;
      v_avg        <= 1'b0;
      v_dz         <= 1'b0;
    end else begin
      if (accept) begin
        sample_count <= last ? '0 : sample_count + 1'b1;
      end
      pending <= pending + PEND_W'(accept && last) - PEND_W'(out_take);
      v_fin   <= accept && last;
      v_prod  <= v_fin;
      v_avg   <= v_prod;
      v_dz    <= v_avg;
    end
  end

  // Six averaging lanes, one for each sensor axis.
  logic signed [ivi_pkg::IN_W-1:0]  accel_in [3];
  logic signed [ivi_pkg::IN_W-1:0]  gyro_in  [3];
  logic signed [ivi_pkg::AVG_W-1:0] accel_avg [3];
  logic signed [ivi_pkg::AVG_W-1:0] gyro_avg  [3];
  logic signed [ivi_pkg::AVG_W-1:0] rate_d    [3];
  logic signed [ivi_pkg::VEL_W-1:0] vel       [3];

  assign accel_in[0] = raw_accel_x;
  assign accel_in[1] = raw_accel_y;
  assign accel_in[2] = raw_accel_z;
  assign gyro_in[0]  = raw_gyro_x;
  assign gyro_in[1]  = raw_gyro_y;
  assign gyro_in[2]  = raw_gyro_z;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    ivi_avg_lane #(
      .AVG_COUNT(AVG_COUNT)
    ) u_accel (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (accel_in[i]),
      .bias   (accel_bias[i]),
      .avg    (accel_avg[i])
    );

    ivi_avg_lane #(
      .AVG_COUNT(AVG_COUNT)
    ) u_gyro (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (gyro_in[i]),
      .bias   (gyro_bias[i]),
      .avg    (gyro_avg[i])
    );

    // The velocity lanes take one more stage for the dead zone.
    ivi_int_lane #(
      .STILL_LIMIT(STILL_LIMIT)
    ) u_int (
      .clk       (clk),
      .rst       (rst),
      .commit    (v_dz),
      .avg       (accel_avg[i]),
      .dead_low  (dead_low),
      .dead_high (dead_high),
      .vel       (vel[i])
    );

    // Gyro averages pass through one register to line up with the velocities.
    always_ff @(posedge clk) begin
      rate_d[i] <= gyro_avg[i];
    end
  end

  // Merge stage: one result item into the output buffer.
  ivi_pkg::result_t res_in;
  ivi_pkg::result_t res_out;

  assign res_in.vel_x  = vel[0];
  assign res_in.vel_y  = vel[1];
  assign res_in.vel_z  = vel[2];
  assign res_in.rate_x = rate_d[0];
  assign res_in.rate_y = rate_d[1];
  assign res_in.rate_z = rate_d[2];

  ivi_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (v_dz),
    .din      (res_in),
    .pop      (out_take),
    .has_item (out_valid),
    .dout     (res_out)
  );

  assign vel_x  = res_out.vel_x;
  assign vel_y  = res_out.vel_y;
  assign vel_z  = res_out.vel_z;
  assign rate_x = res_out.rate_x;
  assign rate_y = res_out.rate_y;
  assign rate_z = res_out.rate_z;

  // The in-flight count never passes the buffer depth.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(ivi_pkg::FIFO_DEPTH))
    else $error("result count exceeds buffer depth");

  // A block-closing sample reaches the buffer via the v_fin, v_prod, v_avg and v_dz stages.
  a_last_to_push: assert property (@(posedge clk) disable iff (rst)
    accept && last |-> ##4 v_dz)
    else $error("averaged result lost in pipeline");

  // Anything offered or in the pipeline is counted as pending.
  a_pending_covers: assert property (@(posedge clk) disable iff (rst)
    (out_valid || v_dz) |-> pending != '0)
    else $error("result present with nothing pending");

endmodule
